[rtl/core/ssosc_pkg.sv]
// ----------------------------------------------------------------------------
// ssosc_pkg
// Shared constants, types and the constant root table for the shaped
// sawtooth oscillator.
// ----------------------------------------------------------------------------
package ssosc_pkg;

    localparam int COUNT_BITS     = 18;
    localparam int SAMPLE_BITS    = 24;
    localparam int FREQ_BITS      = 24;
    localparam int FACTOR_BITS    = 16;
    localparam int RATE_BITS      = 18;
    localparam int AMP_BITS       = 23;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 23;
    localparam int LIM_BITS       = RATE_BITS + 8;
    localparam int PROD_BITS      = COUNT_BITS + FREQ_BITS;
    localparam int FRAC_BITS      = 24;
    localparam int STEP_BITS      = 5;
    localparam int QUEUE_PTR_BITS = 1;
    localparam int QUEUE_DEPTH    = 2 ** QUEUE_PTR_BITS;

    localparam logic [RATE_BITS-1:0] RESET_SAMPLE_RATE = RATE_BITS'(48000);
    localparam logic [AMP_BITS-1:0]  RESET_AMPLITUDE   = AMP_BITS'(8388607);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_AMPLITUDE   = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic                   sat;
        logic [LIM_BITS-1:0]    prod;
        logic [FACTOR_BITS-1:0] factor;
    } ramp_item_t;

    typedef logic [FRAC_BITS-1:0][30:0] root_table_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Successive square roots of one half in Q1.30: 2^(-2^-i), i = 1..24
    function automatic root_table_t exp_roots();
        root_table_t tbl;
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            c      = isqrt64(c << 30);
            tbl[i] = c[30:0];
        end
        return tbl;
    endfunction

    localparam root_table_t EXP_ROOT = exp_roots();

endpackage

[rtl/core/ssosc_queue.sv]
// ----------------------------------------------------------------------------
// ssosc_queue
// Two-entry queue of classified ramp items between front and back.
// ----------------------------------------------------------------------------
module ssosc_queue
    import ssosc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ramp_item_t push_item,
    output logic       full,
    input  logic       pop,
    output ramp_item_t pop_item,
    output logic       empty
);

    ramp_item_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   fill_reg;
    logic [QUEUE_PTR_BITS:0]   fill_next;

    assign full     = (fill_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/ssosc_front.sv]
// ----------------------------------------------------------------------------
// ssosc_front
// Accept ticks, form count*freq, classify the ramp and advance the count.
// ----------------------------------------------------------------------------
module ssosc_front
    import ssosc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FREQ_BITS-1:0]   freq,
    input  logic [FACTOR_BITS-1:0] factor,
    input  logic [RATE_BITS-1:0]   sample_rate,
    input  logic                   q_full,
    output logic                   q_push,
    output ramp_item_t             q_item
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t           state_reg, state_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [FREQ_BITS-1:0]   freq_reg;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    logic [RATE_BITS-1:0]   sr_eff;
    logic [PROD_BITS-1:0]   lim_ext;
    logic [PROD_BITS:0]     step_prod;
    logic                   sat;
    logic                   wrap;
    logic [COUNT_BITS-1:0]  count_inc;

    assign sr_eff    = (sample_rate == '0) ? RATE_BITS'(1) : sample_rate;
    assign lim_ext   = PROD_BITS'({sr_eff, 8'b0});
    assign sat       = (prod_reg >= lim_ext);
    assign step_prod = {1'b0, prod_reg} + (PROD_BITS+1)'(freq_reg);
    assign wrap      = (step_prod > {1'b0, lim_ext});
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    assign in_stall      = (state_reg != F_IDLE);
    assign q_push        = (state_reg == F_PUSH) && !q_full;
    assign q_item.sat    = sat;
    assign q_item.prod   = prod_reg[LIM_BITS-1:0];
    assign q_item.factor = factor_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    // advance the count, drop to zero past the period
                    count_next = wrap ? '0 : count_inc;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            freq_reg   <= freq;
            factor_reg <= factor;
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= count_reg * freq_reg;
        end
    end

endmodule

[rtl/core/ssosc_back.sv]
// ----------------------------------------------------------------------------
// ssosc_back
// Iterative engine: ramp divide, log2, scale, exp2, amplitude, output register.
// ----------------------------------------------------------------------------
module ssosc_back
    import ssosc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  ramp_item_t                    q_item,
    input  logic [RATE_BITS-1:0]          sample_rate,
    input  logic [AMP_BITS-1:0]           amplitude,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    typedef enum logic [10:0] {
        B_IDLE = 11'b00000000001,
        B_DIV  = 11'b00000000010,
        B_ABS  = 11'b00000000100,
        B_NORM = 11'b00000001000,
        B_LOG  = 11'b00000010000,
        B_TMUL = 11'b00000100000,
        B_EXP  = 11'b00001000000,
        B_PSH  = 11'b00010000000,
        B_MAG  = 11'b00100000000,
        B_AMP  = 11'b01000000000,
        B_OUT  = 11'b10000000000
    } back_state_t;

    localparam logic [23:0] ONE_Q23  = 24'h800000;
    localparam logic [30:0] ONE_Q30  = 31'h40000000;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(FRAC_BITS - 1);
    localparam logic [32:0] VMAX = (33'd1 << (SAMPLE_BITS - 1)) - 33'd1;

    back_state_t            state_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic [RATE_BITS-1:0]   rem_reg;
    logic [23:0]            quo_reg;
    logic                   neg_reg;
    logic [23:0]            a_reg;
    logic [30:0]            x_reg;
    logic [STEP_BITS-1:0]   sh_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [32:0]            t_reg;
    logic [30:0]            p_reg;
    logic [23:0]            m_reg;
    logic [24:0]            v_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic [RATE_BITS-1:0]   sr_eff;
    logic [RATE_BITS:0]     rem_sh;
    logic [RATE_BITS:0]     rem_sub;
    logic                   div_ge;
    logic                   abs_neg;
    logic [23:0]            abs_a;
    logic [61:0]            sq;
    logic [31:0]            sq_top;
    logic [30:0]            log_x;
    logic [28:0]            n_val;
    logic [44:0]            tprod;
    logic [STEP_BITS-1:0]   g_idx;
    logic [FRAC_BITS-1:0]   g_bits;
    logic [61:0]            pc;
    logic [8:0]             n_exp;
    logic [30:0]            p_shift;
    logic [55:0]            mag;
    logic [25:0]            m_raw;
    logic [47:0]            vp;
    logic [32:0]            v_ext;
    logic [32:0]            v_lim;
    logic [SAMPLE_BITS-1:0] v_cut;
    logic                   out_free;

    assign sr_eff  = (sample_rate == '0) ? RATE_BITS'(1) : sample_rate;
    assign rem_sh  = {rem_reg, quo_reg[23]};
    assign div_ge  = (rem_sh >= {1'b0, sr_eff});
    assign rem_sub = rem_sh - {1'b0, sr_eff};

    assign abs_neg = (quo_reg < ONE_Q23);
    assign abs_a   = abs_neg ? (ONE_Q23 - quo_reg) : (quo_reg - ONE_Q23);

    assign sq     = x_reg * x_reg;
    assign sq_top = sq[61:30];
    assign log_x  = sq_top[31] ? sq_top[31:1] : sq_top[30:0];

    assign n_val = {sh_reg, 24'b0} - {5'b0, frac_reg};
    assign tprod = n_val * factor_reg;

    assign g_bits  = t_reg[FRAC_BITS-1:0];
    assign g_idx   = LAST_STEP - step_reg;
    assign pc      = p_reg * EXP_ROOT[step_reg];
    assign n_exp   = t_reg[32:24];
    assign p_shift = (n_exp >= 9'd31) ? '0 : (p_reg >> n_exp[4:0]);

    assign mag   = 56'(p_reg * a_reg) + 56'(ONE_Q30 >> 1);
    assign m_raw = mag[55:30];
    assign vp    = 48'(m_reg * amplitude) + 48'(ONE_Q23 >> 1);

    assign v_ext = 33'(v_reg);
    assign v_lim = (v_ext > VMAX) ? VMAX : v_ext;
    assign v_cut = v_lim[SAMPLE_BITS-1:0];

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new result, or drop valid once the held one transfers
            if (state_reg == B_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= q_item.sat ? B_NORM : B_DIV;
                    end
                end
                B_DIV:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= B_ABS;
                    end
                end
                B_ABS:
                begin
                    state_reg <= (abs_a == '0) ? B_OUT : B_NORM;
                end
                B_NORM:
                begin
                    if (x_reg[30])
                    begin
                        state_reg <= B_LOG;
                    end
                end
                B_LOG:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= B_TMUL;
                    end
                end
                B_TMUL:
                begin
                    state_reg <= B_EXP;
                end
                B_EXP:
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= B_PSH;
                    end
                end
                B_PSH:
                begin
                    state_reg <= B_MAG;
                end
                B_MAG:
                begin
                    state_reg <= B_AMP;
                end
                B_AMP:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                factor_reg <= q_item.factor;
                step_reg   <= '0;
                // quotient below 2^24, so the top dividend bits are a valid remainder
                rem_reg    <= q_item.prod[LIM_BITS-1:8];
                quo_reg    <= {q_item.prod[7:0], 16'b0};
                neg_reg    <= 1'b0;
                a_reg      <= ONE_Q23;
                x_reg      <= {ONE_Q23, 7'b0};
                sh_reg     <= '0;
            end
            B_DIV:
            begin
                rem_reg  <= div_ge ? rem_sub[RATE_BITS-1:0] : rem_sh[RATE_BITS-1:0];
                quo_reg  <= {quo_reg[22:0], div_ge};
                step_reg <= step_reg + 1'b1;
            end
            B_ABS:
            begin
                neg_reg <= abs_neg;
                a_reg   <= abs_a;
                x_reg   <= {abs_a, 7'b0};
                sh_reg  <= '0;
                v_reg   <= '0;
            end
            B_NORM:
            begin
                step_reg <= '0;
                frac_reg <= '0;
                if (!x_reg[30])
                begin
                    x_reg  <= {x_reg[29:0], 1'b0};
                    sh_reg <= sh_reg + 1'b1;
                end
            end
            B_LOG:
            begin
                x_reg    <= log_x;
                frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_top[31]};
                step_reg <= step_reg + 1'b1;
            end
            B_TMUL:
            begin
                t_reg    <= tprod[44:12];
                p_reg    <= ONE_Q30;
                step_reg <= '0;
            end
            B_EXP:
            begin
                if (g_bits[g_idx])
                begin
                    p_reg <= pc[60:30];
                end
                step_reg <= step_reg + 1'b1;
            end
            B_PSH:
            begin
                p_reg <= p_shift;
            end
            B_MAG:
            begin
                m_reg <= (m_raw > 26'(ONE_Q23)) ? ONE_Q23 : m_raw[23:0];
            end
            B_AMP:
            begin
                v_reg <= vp[47:23];
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    sample_reg <= neg_reg ? (SAMPLE_BITS'(0) - v_cut) : v_cut;
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    a_div_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (rem_reg < sr_eff))
        else $error("divider remainder reached the divisor");

    a_log_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LOG) |-> x_reg[30])
        else $error("log operand not normalized");

    a_mag_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_AMP) |-> (m_reg <= ONE_Q23))
        else $error("shaped magnitude above full scale");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && out_free) |=> (out_valid_reg && state_reg == B_IDLE))
        else $error("result not loaded into output register");

endmodule

[rtl/core/shaped_sawtooth_oscillator_core.sv]
// ----------------------------------------------------------------------------
// shaped_sawtooth_oscillator_core
// Ramp paths: a zero ramp goes from the divider straight to the output register,
//   a saturated ramp skips the divider, and other ramps run every stage and add
//   normalize shifts; waiting behind a busy back engine adds to the delay.
// Ticks are paced by the iterative back engine; the queue lets the front accept
//   ticks while it runs its 24-step divider, normalize loop, 24-step log2 squarer
//   and 24-step exp2. Reset (rst_n, async low): phase count 0, sample_rate 48000,
//   amplitude max.
module shaped_sawtooth_oscillator_core
    import ssosc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [FREQ_BITS-1:0]          freq,
    input  logic [FACTOR_BITS-1:0]        factor,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    // Configuration registers; the user is to write them only while the block is
    // idle (the block itself does not enforce it), so both halves read them live.
    logic [RATE_BITS-1:0] sample_rate_reg;
    logic [AMP_BITS-1:0]  amplitude_reg;

    // Front-to-back queue handshake
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    ramp_item_t q_push_item;
    ramp_item_t q_pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= RESET_SAMPLE_RATE;
            amplitude_reg   <= RESET_AMPLITUDE;
        end
        else if (cfg_we)
        begin
            // indexes outside the register list drop the write
            if (cfg_index == REG_SAMPLE_RATE)
            begin
                sample_rate_reg <= cfg_data[RATE_BITS-1:0];
            end
            else if (cfg_index == REG_AMPLITUDE)
            begin
                amplitude_reg <= cfg_data[AMP_BITS-1:0];
            end
        end
    end

    // Front: accept a tick, form count*freq, flag ramp saturation, advance count
    ssosc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .freq        (freq),
        .factor      (factor),
        .sample_rate (sample_rate_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_push_item)
    );

    // Short queue so the front can keep counting while the back iterates
    ssosc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    // Back: divide, log2, scale by the exponent, exp2, apply amplitude,
    // hold the result in the output register until transfer
    ssosc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_item      (q_pop_item),
        .sample_rate (sample_rate_reg),
        .amplitude   (amplitude_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample      (sample)
    );

endmodule
